FILE: rtl/binary_max_heap_queue_assert.svh
// ============================================================================
// Assertion macros for the binary max-heap queue
// Short forms for clocked implications with an active-low reset disable.
// ============================================================================
`ifndef BINARY_MAX_HEAP_QUEUE_ASSERT_SVH
`define BINARY_MAX_HEAP_QUEUE_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define BMHQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bmhq: implication check failed");

// Next-cycle implication, checked at every rising clock edge out of reset.
`define BMHQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bmhq: next-cycle check failed");

`endif

FILE: rtl/bmhq_pkg.sv
// ============================================================================
// bmhq_pkg
// Types and codes shared by the binary max-heap queue and its checker.
// ============================================================================
package bmhq_pkg;

    localparam int KEY_W = 16;
    localparam int TAG_W = 8;
    localparam int OCC_W = 7;

    // Operation codes of a request.
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_PEEK   = 2'd2;

    // Completion status of a request.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // One stored heap entry.
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } entry_t;

    // Request payload.
    typedef struct packed {
        logic [1:0]       operation;
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } req_t;

    // Result payload.
    typedef struct packed {
        logic [KEY_W-1:0] out_key;
        logic [TAG_W-1:0] out_tag;
        logic             out_valid;
        status_t          status;
        logic [OCC_W-1:0] occupancy;
    } rsp_t;

endpackage

FILE: rtl/binary_max_heap_queue.sv
// Busy falls in the cycle the result is shown on done.
// One request is handled at a time; the next is taken at the edge ending the result cycle.
// Each heap level takes a memory read step and then a compare/write step on the heap memory.
// Reset: rst_n clears the entry count and control state; heap contents are not cleared.
// The result appears on done for one cycle and cannot be stalled by the receiver.
// ============================================================================
// binary_max_heap_queue
// Array-based max-heap priority queue with insert, pop and peek requests,
// kept in one synchronous memory with two read ports and one write port.
// ============================================================================
module binary_max_heap_queue
    import bmhq_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  req_t request,
    output logic busy,
    output logic done,
    output rsp_t result
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int LNK_W = IDX_W + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_UP_RD,
        S_UP_CMP,
        S_ROOT,
        S_DN_RD,
        S_DN_CMP
    } state_t;

    // Control and result registers.
    state_t             state_reg, state_next;
    req_t               req_reg, req_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [IDX_W-1:0]   pos_reg, pos_next;
    entry_t             cur_reg, cur_next;
    logic               rv_reg, rv_next;
    logic               done_reg, done_next;
    rsp_t               result_reg, result_next;

    // Heap memory and its ports.
    entry_t             heap_mem [DEPTH];
    entry_t             rd0_reg, rd1_reg;
    logic [IDX_W-1:0]   raddr0, raddr1, waddr;
    logic               we;
    entry_t             wdata;

    // Index arithmetic for the current position.
    logic [IDX_W-1:0]   parent_idx;
    logic [LNK_W-1:0]   left_idx, right_idx;
    logic               pick_right;
    entry_t             pick_ent;
    logic [IDX_W-1:0]   pick_idx;

    assign parent_idx = IDX_W'((pos_reg - IDX_W'(1)) >> 1);
    assign left_idx   = {pos_reg, 1'b1};
    assign right_idx  = left_idx + LNK_W'(1);

    // The right child wins ties; it only exists when it was in range.
    assign pick_right = rv_reg && !(rd0_reg.key > rd1_reg.key);
    assign pick_ent   = pick_right ? rd1_reg : rd0_reg;
    assign pick_idx   = pick_right ? right_idx[IDX_W-1:0] : left_idx[IDX_W-1:0];

    // Next-state and memory control.
    always_comb
    begin
        state_next  = state_reg;
        req_next    = req_reg;
        cnt_next    = cnt_reg;
        pos_next    = pos_reg;
        cur_next    = cur_reg;
        rv_next     = rv_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        raddr0      = '0;
        raddr1      = '0;
        waddr       = pos_reg;
        we          = 1'b0;
        wdata       = cur_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next   = request;
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                result_next = '0;
                case (req_reg.operation)
                    OP_INSERT:
                    begin
                        if (cnt_reg == CNT_W'(DEPTH))
                        begin
                            result_next.status    = ST_FULL;
                            result_next.occupancy = OCC_W'(cnt_reg);
                            done_next             = 1'b1;
                            state_next            = S_IDLE;
                        end
                        else
                        begin
                            pos_next   = cnt_reg[IDX_W-1:0];
                            cur_next   = '{key: req_reg.key, tag: req_reg.tag};
                            cnt_next   = cnt_reg + CNT_W'(1);
                            state_next = S_UP_RD;
                        end
                    end

                    OP_POP, OP_PEEK:
                    begin
                        if (cnt_reg == '0)
                        begin
                            result_next.status    = ST_EMPTY;
                            result_next.occupancy = OCC_W'(cnt_reg);
                            done_next             = 1'b1;
                            state_next            = S_IDLE;
                        end
                        else
                        begin
                            // Fetch the root and the last entry together.
                            raddr0     = '0;
                            raddr1     = IDX_W'(cnt_reg - CNT_W'(1));
                            state_next = S_ROOT;
                        end
                    end

                    default:
                    begin
                        result_next.occupancy = OCC_W'(cnt_reg);
                        done_next             = 1'b1;
                        state_next            = S_IDLE;
                    end
                endcase
            end

            S_ROOT:
            begin
                result_next.out_key   = rd0_reg.key;
                result_next.out_tag   = rd0_reg.tag;
                result_next.out_valid = 1'b1;
                if (req_reg.operation == OP_POP)
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                    if (cnt_next == '0)
                    begin
                        result_next.occupancy = OCC_W'(cnt_next);
                        done_next             = 1'b1;
                        state_next            = S_IDLE;
                    end
                    else
                    begin
                        // The last entry becomes the hole's occupant at the root.
                        cur_next   = rd1_reg;
                        pos_next   = '0;
                        state_next = S_DN_RD;
                    end
                end
                else
                begin
                    result_next.occupancy = OCC_W'(cnt_reg);
                    done_next             = 1'b1;
                    state_next            = S_IDLE;
                end
            end

            S_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    we                    = 1'b1;
                    result_next.occupancy = OCC_W'(cnt_reg);
                    done_next             = 1'b1;
                    state_next            = S_IDLE;
                end
                else
                begin
                    raddr0     = parent_idx;
                    state_next = S_UP_CMP;
                end
            end

            S_UP_CMP:
            begin
                // A smaller parent moves down into the hole.
                if (rd0_reg.key < cur_reg.key)
                begin
                    we         = 1'b1;
                    wdata      = rd0_reg;
                    pos_next   = parent_idx;
                    state_next = S_UP_RD;
                end
                else
                begin
                    we                    = 1'b1;
                    result_next.occupancy = OCC_W'(cnt_reg);
                    done_next             = 1'b1;
                    state_next            = S_IDLE;
                end
            end

            S_DN_RD:
            begin
                if (left_idx >= LNK_W'(cnt_reg))
                begin
                    we                    = 1'b1;
                    result_next.occupancy = OCC_W'(cnt_reg);
                    done_next             = 1'b1;
                    state_next            = S_IDLE;
                end
                else
                begin
                    rv_next    = right_idx < LNK_W'(cnt_reg);
                    raddr0     = left_idx[IDX_W-1:0];
                    raddr1     = rv_next ? right_idx[IDX_W-1:0] : left_idx[IDX_W-1:0];
                    state_next = S_DN_CMP;
                end
            end

            S_DN_CMP:
            begin
                // A strictly greater child moves up into the hole.
                if (pick_ent.key > cur_reg.key)
                begin
                    we         = 1'b1;
                    wdata      = pick_ent;
                    pos_next   = pick_idx;
                    state_next = S_DN_RD;
                end
                else
                begin
                    we                    = 1'b1;
                    result_next.occupancy = OCC_W'(cnt_reg);
                    done_next             = 1'b1;
                    state_next            = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            req_reg    <= '0;
            cnt_reg    <= '0;
            pos_reg    <= '0;
            cur_reg    <= '0;
            rv_reg     <= 1'b0;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            req_reg    <= req_next;
            cnt_reg    <= cnt_next;
            pos_reg    <= pos_next;
            cur_reg    <= cur_next;
            rv_reg     <= rv_next;
            done_reg   <= done_next;
            result_reg <= result_next;
        end
    end

    // Heap memory: one write port and two registered read ports.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            heap_mem[waddr] <= wdata;
        end
        rd0_reg <= heap_mem[raddr0];
        rd1_reg <= heap_mem[raddr1];
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: rtl/bmhq_checker.sv
// ============================================================================
// bmhq_checker
// Port-level checks on the binary max-heap queue, bound to the top level.
// ============================================================================
`include "binary_max_heap_queue_assert.svh"

module bmhq_checker
    import bmhq_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input req_t request,
    input logic busy,
    input logic done,
    input rsp_t result
);

    // An accepted request keeps the block busy in the following cycle.
    `BMHQ_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)

    // Results are single-cycle strobes, never back to back.
    `BMHQ_ASSERT_NXT(a_done_pulse, clk, rst_n, done, !done)

    // A returned entry only comes with a good status.
    `BMHQ_ASSERT_IMP(a_valid_ok, clk, rst_n, done && result.out_valid,
        result.status == ST_OK)

    // Without a returned entry the key and tag read as zero.
    `BMHQ_ASSERT_IMP(a_zero_fields, clk, rst_n, done && !result.out_valid,
        result.out_key == '0 && result.out_tag == '0)

    // An empty report means the heap holds nothing.
    `BMHQ_ASSERT_IMP(a_empty_occ, clk, rst_n, done && result.status == ST_EMPTY,
        result.occupancy == '0)

endmodule

bind binary_max_heap_queue bmhq_checker u_bmhq_checker (.*);
